/* sv/pilot_pwm_duty_current_meter_core_assert.svh */
// assertion macros for the pilot duty meter, used by the core top level
// no dependencies; files that assert include this header by name
`ifndef PILOT_PWM_DUTY_CURRENT_METER_CORE_ASSERT_SVH
`define PILOT_PWM_DUTY_CURRENT_METER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PPDCM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define PPDCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPDCM_ASSERT(lbl, clk, rstn, prop, msg)
`define PPDCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/ppdcm_pkg.sv */
// shared types and constants for the pilot duty meter
// used by the controller, the datapath and the top level
package ppdcm_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int WPS_WIDTH       = 10;
    localparam int DUTY_WIDTH      = 10;
    localparam int FREQ_WIDTH      = 24;
    localparam int CUR_WIDTH       = 17;
    localparam int STEP_WIDTH      = 4;

    localparam int WPS_RESET       = 2;
    localparam int DIV_STEPS       = 10;
    localparam int DUTY_SCALE      = 1000;
    localparam int FREQ_MAX        = 16777215;

    // duty bands in tenths of a percent, with the currents and slopes of the bands
    localparam int DUTY_DIG_LO     = 30;
    localparam int DUTY_DIG_HI     = 70;
    localparam int DUTY_GAP_HI     = 80;
    localparam int DUTY_FLAT_HI    = 100;
    localparam int DUTY_LIN_HI     = 850;
    localparam int DUTY_HI_HI      = 960;
    localparam int DUTY_MAX_HI     = 970;
    localparam int CUR_FLAT        = 6000;
    localparam int CUR_SLOPE_LO    = 60;
    localparam int DUTY_OFFSET     = 640;
    localparam int CUR_SLOPE_HI    = 250;
    localparam int CUR_MAX         = 80000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic count;
        logic snap;
        logic div_step;
        logic calc;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/ppdcm_ctrl.sv */
// sequencer for the pilot duty meter: sample intake, division, band lookup, result load
// depends on ppdcm_pkg
module ppdcm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_window_end,
    input  ppdcm_pkg::t_dp_status  i_status,
    output logic                   o_stall,
    output ppdcm_pkg::t_ctrl_cmd   o_cmd
);
    import ppdcm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_window_end) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall        = (r_state != ST_IDLE);
        o_cmd.count    = accept;
        o_cmd.snap     = accept && i_window_end;
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.calc     = (r_state == ST_CALC);
        o_cmd.load     = (r_state == ST_LOAD) && i_status.out_free;
    end

endmodule

/* sv/ppdcm_datapath.sv */
// counters, restoring divider, current band lookup and output register
// depends on ppdcm_pkg; driven by ppdcm_ctrl commands
module ppdcm_datapath #(
    parameter int COUNT_WIDTH = ppdcm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ppdcm_pkg::t_ctrl_cmd               i_cmd,
    output ppdcm_pkg::t_dp_status              o_status,
    input  logic                               i_pilot_level,
    input  logic                               i_cfg_we,
    input  logic [ppdcm_pkg::WPS_WIDTH-1:0]    i_cfg_wdata,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [ppdcm_pkg::DUTY_WIDTH-1:0]   o_duty_tenths,
    output logic [ppdcm_pkg::FREQ_WIDTH-1:0]   o_frequency_hz,
    output logic [ppdcm_pkg::CUR_WIDTH-1:0]    o_current_ma,
    output logic                               o_digital_required,
    output logic                               o_line_steady,
    output logic                               o_steady_polarity_high
);
    import ppdcm_pkg::*;

    localparam int NW = COUNT_WIDTH + 10;
    localparam int PW = COUNT_WIDTH + 9;
    localparam int FW = COUNT_WIDTH + 33;

    logic [COUNT_WIDTH-1:0] cnt_max;
    logic [COUNT_WIDTH-1:0] r_high, r_low, r_chg;
    logic [COUNT_WIDTH-1:0] n_high, n_low, n_chg;
    logic                   r_prev_level, r_prev_valid;
    logic [WPS_WIDTH-1:0]   r_wps;

    logic [NW-1:0]          r_num, r_dsh;
    logic [DUTY_WIDTH-1:0]  r_quot;
    logic [STEP_WIDTH-1:0]  r_step;
    logic [COUNT_WIDTH-2:0] r_half;
    logic                   r_steady, r_pol;

    logic [DUTY_WIDTH-1:0]  r_duty;
    logic [CUR_WIDTH-1:0]   r_cur;
    logic                   r_dig;
    logic [PW-1:0]          r_fprod;

    logic [COUNT_WIDTH:0]   total;
    logic [DUTY_WIDTH-1:0]  duty;
    logic [CUR_WIDTH-1:0]   cur;
    logic                   dig;
    logic [FW-1:0]          fext;
    logic [FREQ_WIDTH-1:0]  freq_sat;
    logic                   r_out_valid;

    assign cnt_max = {COUNT_WIDTH{1'b1}};

    // saturating next counts for the sample being accepted
    always_comb begin
        n_high = r_high;
        n_low  = r_low;
        n_chg  = r_chg;
        if (i_pilot_level) begin
            if (r_high != cnt_max) n_high = COUNT_WIDTH'(r_high + 1'b1);
        end else begin
            if (r_low != cnt_max) n_low = COUNT_WIDTH'(r_low + 1'b1);
        end
        if (r_prev_valid && (i_pilot_level != r_prev_level) && (r_chg != cnt_max)) begin
            n_chg = COUNT_WIDTH'(r_chg + 1'b1);
        end
        total = (COUNT_WIDTH+1)'(n_high) + (COUNT_WIDTH+1)'(n_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high       <= '0;
            r_low        <= '0;
            r_chg        <= '0;
            r_prev_level <= 1'b0;
            r_prev_valid <= 1'b0;
            r_wps        <= WPS_WIDTH'(WPS_RESET);
        end else begin
            if (i_cfg_we) begin
                r_wps <= i_cfg_wdata;
            end
            if (i_cmd.count) begin
                r_prev_level <= i_pilot_level;
                if (i_cmd.snap) begin
                    r_high       <= '0;
                    r_low        <= '0;
                    r_chg        <= '0;
                    r_prev_valid <= 1'b0;
                end else begin
                    r_high       <= n_high;
                    r_low        <= n_low;
                    r_chg        <= n_chg;
                    r_prev_valid <= 1'b1;
                end
            end
        end
    end

    // window snapshot and one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            // high * 1000 as 1024 - 16 - 8
            r_num    <= (NW'(n_high) << 10) - (NW'(n_high) << 4) - (NW'(n_high) << 3);
            r_dsh    <= NW'(total) << (DIV_STEPS - 1);
            r_quot   <= '0;
            r_step   <= STEP_WIDTH'(DIV_STEPS - 1);
            r_half   <= n_chg[COUNT_WIDTH-1:1];
            r_steady <= (n_chg == '0);
            r_pol    <= !(n_low > n_high);
        end else if (i_cmd.div_step) begin
            if (r_num >= r_dsh) begin
                r_num  <= r_num - r_dsh;
                r_quot <= {r_quot[DUTY_WIDTH-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[DUTY_WIDTH-2:0], 1'b0};
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= STEP_WIDTH'(r_step - 1'b1);
        end
    end

    // current bands
    always_comb begin
        duty = (r_quot == DUTY_WIDTH'(DUTY_SCALE)) ? '0 : r_quot;
        dig  = (duty >= DUTY_WIDTH'(DUTY_DIG_LO)) && (duty <= DUTY_WIDTH'(DUTY_DIG_HI));
        priority if (duty < DUTY_WIDTH'(DUTY_GAP_HI)) begin
            cur = '0;
        end else if (duty <= DUTY_WIDTH'(DUTY_FLAT_HI)) begin
            cur = CUR_WIDTH'(CUR_FLAT);
        end else if (duty <= DUTY_WIDTH'(DUTY_LIN_HI)) begin
            cur = CUR_WIDTH'(CUR_WIDTH'(duty) * CUR_WIDTH'(CUR_SLOPE_LO));
        end else if (duty <= DUTY_WIDTH'(DUTY_HI_HI)) begin
            cur = CUR_WIDTH'((CUR_WIDTH'(duty) - CUR_WIDTH'(DUTY_OFFSET))
                             * CUR_WIDTH'(CUR_SLOPE_HI));
        end else if (duty <= DUTY_WIDTH'(DUTY_MAX_HI)) begin
            cur = CUR_WIDTH'(CUR_MAX);
        end else begin
            cur = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_duty  <= duty;
            r_cur   <= cur;
            r_dig   <= dig;
            r_fprod <= PW'(PW'(r_half) * PW'(r_wps));
        end
    end

    always_comb begin
        fext     = FW'(r_fprod);
        freq_sat = (fext > FW'(FREQ_MAX)) ? FREQ_WIDTH'(FREQ_MAX) : fext[FREQ_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_duty_tenths          <= r_steady ? '0 : r_duty;
            o_frequency_hz         <= r_steady ? '0 : freq_sat;
            o_current_ma           <= r_steady ? '0 : r_cur;
            o_digital_required     <= r_steady ? 1'b0 : r_dig;
            o_line_steady          <= r_steady;
            o_steady_polarity_high <= r_pol;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status.div_last = (r_step == '0);
    assign o_status.out_free = !r_out_valid || !i_stall;

endmodule

/* sv/pilot_pwm_duty_current_meter_core.sv */
// Control-pilot duty meter. One pilot sample is taken per transaction on the input
// channel (i_valid / o_stall); i_window_end marks the last sample of a window.
// Samples are taken every clock while no window result is being worked out.
// The transaction that carries i_window_end starts the result: the high duty is
// found by a restoring divider, one quotient bit per clock, then the calc step
// registers the duty, current band and frequency product and the load step loads
// the output register; o_stall stays high until the load step has loaded it.
// The output register holds a result until the receiver drops i_stall; while it
// waits, the next window's samples are still taken, and a finished result waits in
// the load step (input stalled) until the register is free.
// Synchronous active-low reset clears the counters, empties the output register
// and sets windows per second to 2. i_cfg_we writes windows per second from
// i_cfg_wdata; write it only while no window result is pending.
// depends on ppdcm_pkg, ppdcm_ctrl, ppdcm_datapath and the assertion header
`include "pilot_pwm_duty_current_meter_core_assert.svh"

module pilot_pwm_duty_current_meter_core #(
    parameter int COUNT_WIDTH = ppdcm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppdcm_pkg::WPS_WIDTH-1:0]    i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_pilot_level,
    input  logic                               i_window_end,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ppdcm_pkg::DUTY_WIDTH-1:0]   o_duty_tenths,
    output logic [ppdcm_pkg::FREQ_WIDTH-1:0]   o_frequency_hz,
    output logic [ppdcm_pkg::CUR_WIDTH-1:0]    o_current_ma,
    output logic                               o_digital_required,
    output logic                               o_line_steady,
    output logic                               o_steady_polarity_high
);
    import ppdcm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ppdcm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_window_end (i_window_end),
        .i_status     (status),
        .o_stall      (o_stall),
        .o_cmd        (cmd)
    );

    ppdcm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_pilot_level          (i_pilot_level),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_stall                (i_stall),
        .o_valid                (o_valid),
        .o_duty_tenths          (o_duty_tenths),
        .o_frequency_hz         (o_frequency_hz),
        .o_current_ma           (o_current_ma),
        .o_digital_required     (o_digital_required),
        .o_line_steady          (o_line_steady),
        .o_steady_polarity_high (o_steady_polarity_high)
    );

    `PPDCM_ASSERT(a_busy_after_window, i_clk, i_rst_n, (i_valid && !o_stall && i_window_end) |=> o_stall, "input taken while window result pending")
    `PPDCM_ASSERT(a_steady_zero, i_clk, i_rst_n, (o_valid && o_line_steady) |-> (o_duty_tenths == '0 && o_frequency_hz == '0 && o_current_ma == '0), "steady window with nonzero measurement")
    `PPDCM_ASSERT(a_digital_no_current, i_clk, i_rst_n, (o_valid && o_digital_required) |-> (o_current_ma == '0), "current given in digital band")
    `PPDCM_ASSERT(a_duty_range, i_clk, i_rst_n, o_valid |-> (o_duty_tenths < DUTY_WIDTH'(DUTY_SCALE)), "duty out of range")

endmodule

/* tb/pilot_pwm_duty_current_meter_core_checker.sv */
`timescale 1ns / 100ps
// checker for the pilot duty meter: tracks accepted samples and config writes,
// predicts each window result and compares it with the results taken downstream
// depends on ppdcm_pkg
module pilot_pwm_duty_current_meter_core_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppdcm_pkg::WPS_WIDTH-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_pilot_level,
    input  logic                                i_window_end,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [ppdcm_pkg::DUTY_WIDTH-1:0]    i_duty_tenths,
    input  logic [ppdcm_pkg::FREQ_WIDTH-1:0]    i_frequency_hz,
    input  logic [ppdcm_pkg::CUR_WIDTH-1:0]     i_current_ma,
    input  logic                                i_digital_required,
    input  logic                                i_line_steady,
    input  logic                                i_steady_polarity_high,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import ppdcm_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DUTY_WIDTH-1:0] duty;
        logic [FREQ_WIDTH-1:0] freq;
        logic [CUR_WIDTH-1:0]  current;
        logic                  digital;
        logic                  steady;
        logic                  pol_high;
    } t_meter_result;

    logic [COUNT_WIDTH_DEF-1:0] high_cnt;
    logic [COUNT_WIDTH_DEF-1:0] low_cnt;
    logic [COUNT_WIDTH_DEF-1:0] change_cnt;
    logic                       last_level;
    logic                       last_seen;
    logic [WPS_WIDTH-1:0]       wps;
    t_meter_result              pending_windows[$];
    int                         mismatches = 0;

    function automatic t_meter_result window_result(input longint unsigned highs, lows,
                                                    changes, rate);
        t_meter_result   r;
        longint unsigned duty;
        longint unsigned freq;
        r = '0;
        r.pol_high = (lows > highs) ? 1'b0 : 1'b1;
        r.steady   = (changes == 0);
        if (!r.steady) begin
            duty = (highs * DUTY_SCALE / (highs + lows)) % DUTY_SCALE;
            freq = (changes / 2) * rate;
            if (freq > FREQ_MAX)
                freq = FREQ_MAX;
            r.duty = duty[DUTY_WIDTH-1:0];
            r.freq = freq[FREQ_WIDTH-1:0];
            // everything outside these bands allows no current
            if (duty >= DUTY_DIG_LO && duty <= DUTY_DIG_HI)
                r.digital = 1'b1;
            else if (duty >= DUTY_GAP_HI && duty <= DUTY_FLAT_HI)
                r.current = CUR_WIDTH'(CUR_FLAT);
            else if (duty > DUTY_FLAT_HI && duty <= DUTY_LIN_HI)
                r.current = CUR_WIDTH'(duty * CUR_SLOPE_LO);
            else if (duty > DUTY_LIN_HI && duty <= DUTY_HI_HI)
                r.current = CUR_WIDTH'((duty - DUTY_OFFSET) * CUR_SLOPE_HI);
            else if (duty > DUTY_HI_HI && duty <= DUTY_MAX_HI)
                r.current = CUR_WIDTH'(CUR_MAX);
        end
        return r;
    endfunction

    task automatic report(input string what, input t_meter_result want,
                          input t_meter_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected duty %0d freq %0d cur %0d dig %0b steady %0b pol %0b",
                     $realtime, what, want.duty, want.freq, want.current, want.digital,
                     want.steady, want.pol_high);
            $display("    actual duty %0d freq %0d cur %0d dig %0b steady %0b pol %0b",
                     got.duty, got.freq, got.current, got.digital, got.steady, got.pol_high);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_meter_result got;
        t_meter_result want;
        if (!i_rst_n) begin
            high_cnt   = '0;
            low_cnt    = '0;
            change_cnt = '0;
            last_level = 1'b0;
            last_seen  = 1'b0;
            wps        = WPS_WIDTH'(WPS_RESET);
            pending_windows.delete();
        end else begin
            if (i_cfg_we)
                wps = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_pilot_level) begin
                    if (high_cnt != '1)
                        high_cnt++;
                end else if (low_cnt != '1) begin
                    low_cnt++;
                end
                if (last_seen && i_pilot_level != last_level && change_cnt != '1)
                    change_cnt++;
                last_level = i_pilot_level;
                last_seen  = 1'b1;
                if (i_window_end) begin
                    pending_windows.push_back(window_result(64'(high_cnt), 64'(low_cnt),
                                                            64'(change_cnt), 64'(wps)));
                    high_cnt   = '0;
                    low_cnt    = '0;
                    change_cnt = '0;
                    last_seen  = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_duty_tenths, i_frequency_hz, i_current_ma, i_digital_required,
                        i_line_steady, i_steady_polarity_high};
                if (pending_windows.size() == 0) begin
                    report("result with no window pending", '0, got);
                end else begin
                    want = pending_windows.pop_front();
                    if (got !== want)
                        report("result mismatch", want, got);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_windows.size();
    end

endmodule

/* tb/pilot_pwm_duty_current_meter_core_tb.sv */
`timescale 1ns / 100ps
// top of the pilot duty meter testbench: clock, reset, sample stimulus,
// receiver stalls, watchdog and verdict; checking is done in the checker module
// depends on ppdcm_pkg, the meter core and its checker
module pilot_pwm_duty_current_meter_core_tb;
    import ppdcm_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 110;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [WPS_WIDTH-1:0]  i_cfg_wdata   = '0;
    logic                  i_valid       = 1'b0;
    logic                  i_pilot_level = 1'b0;
    logic                  i_window_end  = 1'b0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [DUTY_WIDTH-1:0] o_duty_tenths;
    logic [FREQ_WIDTH-1:0] o_frequency_hz;
    logic [CUR_WIDTH-1:0]  o_current_ma;
    logic                  o_digital_required;
    logic                  o_line_steady;
    logic                  o_steady_polarity_high;

    int fail_count;
    int pending;
    int items_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_tag     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int duty_edges[16] = '{20, 29, 30, 70, 71, 79, 80, 100, 101, 850, 851, 960, 961, 970,
                           971, 980};

    always #1 i_clk = ~i_clk;

    pilot_pwm_duty_current_meter_core dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_pilot_level          (i_pilot_level),
        .i_window_end           (i_window_end),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_duty_tenths          (o_duty_tenths),
        .o_frequency_hz         (o_frequency_hz),
        .o_current_ma           (o_current_ma),
        .o_digital_required     (o_digital_required),
        .o_line_steady          (o_line_steady),
        .o_steady_polarity_high (o_steady_polarity_high)
    );

    pilot_pwm_duty_current_meter_core_checker checker_i (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_in_valid             (i_valid),
        .i_in_stall             (o_stall),
        .i_pilot_level          (i_pilot_level),
        .i_window_end           (i_window_end),
        .i_out_valid            (o_valid),
        .i_out_stall            (i_stall),
        .i_duty_tenths          (o_duty_tenths),
        .i_frequency_hz         (o_frequency_hz),
        .i_current_ma           (o_current_ma),
        .i_digital_required     (o_digital_required),
        .i_line_steady          (o_line_steady),
        .i_steady_polarity_high (o_steady_polarity_high),
        .o_fail_count           (fail_count),
        .o_pending              (pending)
    );

    // receiver: random stalls, or a long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic lvl, input logic wend);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pilot_level <= lvl;
        i_window_end  <= wend;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // high and low runs split over a number of pulses, window end on the last sample
    task automatic send_pulse_window(input int highs, input int lows, input int pulses,
                                     input bit low_first);
        int   left;
        int   run;
        logic lvl;
        left = highs + lows;
        for (int j = 0; j < pulses; j++) begin
            for (int half = 0; half < 2; half++) begin
                lvl = (half == 0) ? !low_first : low_first;
                run = lvl ? highs / pulses + (j < highs % pulses)
                          : lows / pulses + (j < lows % pulses);
                repeat (run) begin
                    left--;
                    send_sample(lvl, left == 0);
                end
            end
        end
    endtask

    task automatic send_counts(input int highs, input int lows);
        int cap;
        cap = (highs < lows) ? highs : lows;
        if (cap < 1)
            cap = 1;
        if (cap > 8)
            cap = 8;
        send_pulse_window(highs, lows, $urandom_range(1, cap), 1'($urandom_range(1)));
    endtask

    // smallest window whose truncated duty lands exactly on the target
    task automatic send_duty_window(input int target);
        int highs;
        for (int total = 2; total <= 1000; total++) begin
            highs = (target * total + 999) / 1000;
            if (highs > 0 && highs < total && highs * 1000 / total == target) begin
                send_counts(highs, total - highs);
                return;
            end
        end
    endtask

    task automatic send_random_bits(input int len, input bit noisy);
        for (int k = 0; k < len; k++)
            send_sample(1'($urandom_range(1)),
                        noisy ? ($urandom_range(3) == 0) : (k == len - 1));
    endtask

    task automatic send_random_window();
        int kind;
        int len;
        int total;
        kind  = $urandom_range(99);
        len   = $urandom_range(1, 24);
        total = $urandom_range(2, 48);
        if (kind < 10) begin
            send_duty_window(duty_edges[$urandom_range(15)]);
        end else if (kind < 50) begin
            send_counts(total - len % (total + 1), len % (total + 1));
        end else if (kind < 70) begin
            send_random_bits(len, 1'b0);
        end else if (kind < 85) begin
            if ($urandom_range(1))
                send_pulse_window(len, 0, 1, 1'b0);
            else
                send_pulse_window(0, len, 1, 1'b1);
        end else begin
            send_random_bits(len, 1'b1);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic write_rate(input logic [WPS_WIDTH-1:0] rate);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int phase_start;
        logic [WPS_WIDTH-1:0] rate;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 38;
        rx_stall_pct <= 56;

        // short windows at the reset rate
        send_pulse_window(1, 0, 1, 1'b0);
        send_pulse_window(0, 1, 1, 1'b1);
        send_pulse_window(1, 1, 1, 1'b0);
        send_pulse_window(4, 4, 4, 1'b1);
        send_pulse_window(3, 1, 1, 1'b0);
        send_pulse_window(1, 3, 1, 1'b1);
        send_pulse_window(0, 3, 1, 1'b1);
        send_pulse_window(2, 2, 1, 1'b1);
        // current band edges
        foreach (duty_edges[e])
            send_duty_window(duty_edges[e]);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: rate = WPS_WIDTH'(1000);
                1: rate = WPS_WIDTH'(1);
                2: rate = WPS_WIDTH'(1023);
                3: rate = WPS_WIDTH'(0);
                4: rate = WPS_WIDTH'($urandom_range(2, 999));
                default: rate = WPS_WIDTH'(1000);
            endcase
            if (ph == 2) begin
                tx_idle_pct = 56;
                rx_stall_pct <= 38;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            write_rate(rate);
            phase_start = items_sent;
            if (ph == 1) begin
                // receiver holds off while short windows keep coming
                hold_tag <= hold_tag + 1;
                repeat (15) send_random_bits(3, 1'b0);
            end
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_window();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
